>>> hdl/edd_pkg.sv
// Package for the error diffusion dither: shared types, constants and codes.
// No dependencies; every file in hdl/ but edd_if.sv uses it by scoped names.
package edd_pkg;

  localparam int MaxWidthDef  = 2048;
  localparam int ErrW         = 10;
  localparam int Chans        = 3;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrW    = 2;
  localparam int DivCycles    = 4;
  localparam int DivBitsStep  = 4;
  localparam int DivCntW      = 2;
  localparam int CfgAddrW     = 4;

  localparam logic [11:0] WidthRst  = 12'd640;
  localparam logic [15:0] HeightRst = 16'd480;
  localparam logic [7:0]  LevelsRst = 8'd1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LEVELS = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE, B_RD0, B_RD1, B_ADD, B_MUL, B_LVL, B_DIV, B_WB
  } back_state_t;

  typedef struct packed {
    logic [11:0] width;
    logic [15:0] height;
    logic [7:0]  levels;
  } cfg_t;

  typedef logic [Chans-1:0][ErrW-1:0] err3_t;
  typedef logic [Chans-1:0][7:0]      pix3_t;

  // front-to-back queue entry; column is kept at the full 16 bits and cut
  // to the line buffer index width in the back end
  typedef struct packed {
    pix3_t       pix;
    logic [15:0] col;
    logic        first_col;
    logic        row_nz;
    logic        last_col;
    logic        frame_done;
  } entry_t;

endpackage

>>> hdl/edd_if.sv
// Stream channel interfaces for the dither: pixel input and result output.
// Depends on nothing but the valid/ready handshake convention.
interface edd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  modport source(output valid, output blue_in, output green_in, output red_in, input ready);
  modport sink(input valid, input blue_in, input green_in, input red_in, output ready);
endinterface

interface edd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_done;
  modport source(output valid, output blue_out, output green_out, output red_out,
                 output frame_done, input ready);
  modport sink(input valid, input blue_out, input green_out, input red_out,
               input frame_done, output ready);
endinterface

>>> hdl/edd_div.sv
// Iterative unsigned divider, 16-bit dividend by 8-bit divisor, 4 bits a cycle while step is high.
// Uses edd_pkg for step constants.
module edd_div (
  input  logic        clk,
  input  logic        start,
  input  logic        step,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic [7:0]  quotient
);

  logic [8:0]  rem_r, rem_nxt;
  logic [15:0] dq_r, dq_nxt;
  logic [7:0]  dvs_r;

  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int i = 0; i < edd_pkg::DivBitsStep; i++) begin
      rem_nxt = {rem_nxt[7:0], dq_nxt[15]};
      dq_nxt  = {dq_nxt[14:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt   = rem_nxt - {1'b0, dvs_r};
        dq_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign quotient = dq_r[7:0];

endmodule

>>> hdl/edd_front.sv
// Front end: accepts pixel beats, tracks raster position, queues entries.
// Uses edd_pkg (entry_t, cfg_t) and edd_pix_if.
module edd_front #(
  parameter int MAX_WIDTH = edd_pkg::MaxWidthDef
) (
  input  logic           clk,
  input  logic           rst_n,
  edd_pix_if.sink        in_pix,
  input  edd_pkg::cfg_t  cfg,
  input  logic           pop,
  output logic           q_valid,
  output edd_pkg::entry_t q_head
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  edd_pkg::entry_t queue_r [edd_pkg::QueueDepth];
  logic [edd_pkg::QueuePtrW-1:0] wp_r, rp_r;
  logic [edd_pkg::QueuePtrW:0]   cnt_r;
  logic [AW-1:0] col_r;
  logic [15:0]   row_r;
  logic          push, full;
  logic [CW-1:0] w_eff, c_plus;
  logic [15:0]   h_eff;
  logic          last_col, last_row;
  edd_pkg::entry_t ent;

  assign full         = (cnt_r == (edd_pkg::QueuePtrW+1)'(edd_pkg::QueueDepth));
  assign in_pix.ready = !full;
  assign push         = in_pix.valid && !full;
  assign q_valid      = (cnt_r != '0);
  assign q_head       = queue_r[rp_r];

  always_comb begin
    if (cfg.width == '0)
      w_eff = CW'(1);
    else if (32'(cfg.width) > MAX_WIDTH)
      w_eff = CW'(MAX_WIDTH);
    else
      w_eff = CW'(cfg.width);
    h_eff    = (cfg.height == '0) ? 16'd1 : cfg.height;
    c_plus   = {1'b0, col_r} + CW'(1);
    last_col = (c_plus >= w_eff);
    last_row = ({1'b0, row_r} + 17'd1 >= {1'b0, h_eff});
    ent.pix        = {in_pix.red_in, in_pix.green_in, in_pix.blue_in};
    ent.col        = 16'(col_r);
    ent.first_col  = (col_r == '0);
    ent.row_nz     = (row_r != '0);
    ent.last_col   = last_col;
    ent.frame_done = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? 16'd0 : row_r + 16'd1;
        end else begin
          col_r <= AW'(c_plus);
        end
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (edd_pkg::QueuePtrW+1)'(push) - (edd_pkg::QueuePtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue_r[wp_r] <= ent;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (edd_pkg::QueuePtrW+1)'(edd_pkg::QueueDepth)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count lost a push");

endmodule

>>> hdl/edd_back.sv
// Back end: error diffusion, quantization and line buffer for one pixel at a time.
// Uses edd_pkg, edd_res_if and three edd_div instances.
module edd_back #(
  parameter int MAX_WIDTH = edd_pkg::MaxWidthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  edd_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  edd_pkg::entry_t q_head,
  output logic            pop,
  edd_res_if.source       out_res
);

  localparam int AW = $clog2(MAX_WIDTH);

  edd_pkg::back_state_t state_r, state_nxt;

  logic [3*edd_pkg::ErrW-1:0] mem [MAX_WIDTH];
  logic [3*edd_pkg::ErrW-1:0] rdata_r;
  logic          rd_en, wr_en, div_start, div_step, out_load;
  logic [AW-1:0] rd_addr;

  edd_pkg::entry_t item_r;
  edd_pkg::err3_t  above_r, aleft_r, left_r, ar_r, err_cur;
  edd_pkg::pix3_t  a_r, a_nxt, quo;
  logic [edd_pkg::Chans-1:0][15:0] prod_r, dividend;
  logic [edd_pkg::DivCntW-1:0] div_cnt_r;
  logic [7:0] lv;
  edd_pkg::err3_t ar_sel;

  logic       out_valid_r;
  edd_pkg::pix3_t out_pix_r;
  logic       out_done_r;

  function automatic logic [7:0] sat_add(input logic [7:0] a,
                                         input logic signed [edd_pkg::ErrW-1:0] e,
                                         input logic [2:0] w);
    logic signed [13:0] p;
    logic signed [10:0] v;
    p = $signed(14'(e)) * $signed({11'b0, w});
    v = $signed({3'b0, a}) + $signed(11'(p >>> 4));
    if (v < 0)
      return 8'd0;
    else if (v > 11'sd255)
      return 8'd255;
    else
      return v[7:0];
  endfunction

  assign lv = (cfg.levels == '0) ? 8'd1 : cfg.levels;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    div_step  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      edd_pkg::B_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          state_nxt = edd_pkg::B_RD0;
        end
      end
      edd_pkg::B_RD0: begin
        rd_en     = 1'b1;
        state_nxt = edd_pkg::B_RD1;
      end
      edd_pkg::B_RD1: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(item_r.col + 16'd1);
        state_nxt = edd_pkg::B_ADD;
      end
      edd_pkg::B_ADD: state_nxt = edd_pkg::B_MUL;
      edd_pkg::B_MUL: state_nxt = edd_pkg::B_LVL;
      edd_pkg::B_LVL: begin
        div_start = 1'b1;
        state_nxt = edd_pkg::B_DIV;
      end
      edd_pkg::B_DIV: begin
        div_step = 1'b1;
        if (div_cnt_r == edd_pkg::DivCntW'(edd_pkg::DivCycles - 1))
          state_nxt = edd_pkg::B_WB;
      end
      edd_pkg::B_WB: begin
        if (!out_valid_r || out_res.ready) begin
          wr_en     = 1'b1;
          out_load  = 1'b1;
          state_nxt = edd_pkg::B_IDLE;
        end
      end
      default: state_nxt = edd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    ar_sel = (item_r.row_nz && !item_r.last_col) ? rdata_r : '0;
    for (int k = 0; k < edd_pkg::Chans; k++) begin
      a_nxt[k] = sat_add(item_r.pix[k], $signed(aleft_r[k]), 3'd1);
      a_nxt[k] = sat_add(a_nxt[k], $signed(above_r[k]), 3'd5);
      a_nxt[k] = sat_add(a_nxt[k], $signed(ar_sel[k]), 3'd3);
      a_nxt[k] = sat_add(a_nxt[k], $signed(left_r[k]), 3'd7);
    end
  end

  always_comb begin
    logic [15:0] y;
    logic [7:0]  t;
    logic [16:0] rem;
    logic [7:0]  level;
    for (int k = 0; k < edd_pkg::Chans; k++) begin
      y     = prod_r[k] + 16'd127;
      t     = y[15:8];
      rem   = {1'b0, y} - (({9'b0, t} << 8) - {9'b0, t});
      level = (rem >= 17'd255) ? t + 8'd1 : t;
      dividend[k] = ({8'b0, level} << 8) - {8'b0, level};
      err_cur[k]  = edd_pkg::ErrW'($signed({2'b0, a_r[k]}) - $signed({2'b0, quo[k]}));
    end
  end

  for (genvar g = 0; g < edd_pkg::Chans; g++) begin : g_div
    edd_div u_div (
      .clk      (clk),
      .start    (div_start),
      .step     (div_step),
      .dividend (dividend[g]),
      .divisor  (lv),
      .quotient (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(item_r.col)] <= err_cur;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edd_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
      above_r     <= '0;
      aleft_r     <= '0;
      left_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_res.ready)
        out_valid_r <= 1'b0;
      div_cnt_r <= div_step ? div_cnt_r + 1'b1 : '0;
      if (state_r == edd_pkg::B_RD1 && item_r.first_col) begin
        aleft_r <= '0;
        left_r  <= '0;
        above_r <= item_r.row_nz ? rdata_r : '0;
      end
      if (wr_en) begin
        left_r  <= err_cur;
        aleft_r <= above_r;
        above_r <= ar_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= q_head;
    if (state_r == edd_pkg::B_ADD) begin
      a_r  <= a_nxt;
      ar_r <= ar_sel;
    end
    if (state_r == edd_pkg::B_MUL) begin
      for (int k = 0; k < edd_pkg::Chans; k++)
        prod_r[k] <= {8'b0, lv} * {8'b0, a_r[k]};
    end
    if (out_load) begin
      out_pix_r  <= quo;
      out_done_r <= item_r.frame_done;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.blue_out   = out_pix_r[0];
  assign out_res.green_out  = out_pix_r[1];
  assign out_res.red_out    = out_pix_r[2];
  assign out_res.frame_done = out_done_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == edd_pkg::B_RD0) else $error("pop outside idle");
  a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edd_pkg::B_WB && out_valid_r && !out_res.ready) |=> state_r == edd_pkg::B_WB)
    else $error("result overwritten under stall");
  a_wr_load: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid_r) else $error("line buffer write without result");

endmodule

>>> hdl/error_diffusion_dither.sv
// Top level of the error diffusion dither: config registers, front and back ends.
// Uses edd_pkg, edd_if, edd_front and edd_back.
//
//   channel  dir  payload                                   handshake
//   in_pix   in   blue_in, green_in, red_in                 valid/ready
//   out_res  out  blue_out, green_out, red_out, frame_done  valid/ready
//   cfg_*    in   APB regs: width @0, height @4, levels @8  psel/penable
//
// In the back end a pixel goes through queue pop, two line buffer reads, adds,
// multiply, level, the radix-16 divider and write back. The front queue holds
// four beats, so input keeps flowing while a result stalls, until it is full.
// rst_n is synchronous; line buffer contents are not cleared.
module error_diffusion_dither #(
  parameter int MAX_WIDTH = edd_pkg::MaxWidthDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  edd_pix_if.sink                     in_pix,
  edd_res_if.source                   out_res,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [edd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  edd_pkg::cfg_t    cfg_r;
  edd_pkg::reg_idx_t idx;
  edd_pkg::entry_t  q_head;
  logic             q_valid, pop, wr;

  assign cfg_pready = 1'b1;
  assign idx        = edd_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= edd_pkg::WidthRst;
      cfg_r.height <= edd_pkg::HeightRst;
      cfg_r.levels <= edd_pkg::LevelsRst;
    end else if (wr) begin
      unique case (idx)
        edd_pkg::REG_WIDTH:  cfg_r.width  <= cfg_pwdata[11:0];
        edd_pkg::REG_HEIGHT: cfg_r.height <= cfg_pwdata[15:0];
        edd_pkg::REG_LEVELS: cfg_r.levels <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      edd_pkg::REG_WIDTH:  cfg_prdata = {20'b0, cfg_r.width};
      edd_pkg::REG_HEIGHT: cfg_prdata = {16'b0, cfg_r.height};
      edd_pkg::REG_LEVELS: cfg_prdata = {24'b0, cfg_r.levels};
      default:             cfg_prdata = '0;
    endcase
  end

  edd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .cfg     (cfg_r),
    .pop     (pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  edd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

>>> dv/error_diffusion_dither_test.sv
// Self-checking test of the error diffusion dither: directed table, then random pixels.
// Depends on edd_pkg, edd_if and error_diffusion_dither from hdl/.
module error_diffusion_dither_test;

  localparam int LimitCycles = 2000000;

  typedef struct {
    logic [7:0] b, g, r;
    logic [7:0] xb, xg, xr; // typed expectation, valid when has_x
    logic       has_x;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b, g, r;
    logic       done;
  } pix_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [edd_pkg::CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  edd_pix_if in_pix();
  edd_res_if out_res();

  error_diffusion_dither uut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix), .out_res(out_res),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // predictor state
  int unsigned fw = 640, fh = 480, lvls = 1;
  int line_err[edd_pkg::MaxWidthDef][3];
  int ul_err[3], up_err[3], lf_err[3];
  int unsigned col_pos, row_pos;

  pix_res_t dither_expect[$];
  int fails = 0;
  int unsigned cycles = 0;

  function automatic int fdiv16(int p);
    return p >= 0 ? p / 16 : -((-p + 15) / 16);
  endfunction

  function automatic int sat_add(int a, int e, int w);
    int v;
    v = a + fdiv16(e * w);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic pix_res_t dither_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned w, h, c;
    int lv, a, lvl, q;
    int ur[3], cur[3], px[3];
    bit lc, lr;
    pix_res_t res;
    w = fw == 0 ? 1 : (fw > edd_pkg::MaxWidthDef ? edd_pkg::MaxWidthDef : fw);
    h = fh == 0 ? 1 : fh;
    lv = lvls == 0 ? 1 : lvls;
    c = col_pos >= edd_pkg::MaxWidthDef ? edd_pkg::MaxWidthDef - 1 : col_pos;
    lc = c + 1 >= w;
    lr = row_pos + 1 >= h;
    px[0] = b; px[1] = g; px[2] = r;
    for (int k = 0; k < 3; k++) begin
      if (c == 0) begin
        ul_err[k] = 0;
        lf_err[k] = 0;
        up_err[k] = row_pos > 0 ? line_err[0][k] : 0;
      end
      ur[k] = (row_pos > 0 && !lc) ? line_err[c + 1][k] : 0;
      a = sat_add(px[k], ul_err[k], 1);
      a = sat_add(a, up_err[k], 5);
      a = sat_add(a, ur[k], 3);
      a = sat_add(a, lf_err[k], 7);
      lvl = (2 * lv * a + 255) / 510;
      q = (lvl * 255) / lv;
      cur[k] = a - q;
      px[k] = q;
    end
    res.b = 8'(px[0]); res.g = 8'(px[1]); res.r = 8'(px[2]);
    res.done = lc && lr;
    for (int k = 0; k < 3; k++) begin
      line_err[c][k] = cur[k];
      lf_err[k] = cur[k];
      ul_err[k] = up_err[k];
      up_err[k] = ur[k];
    end
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : (row_pos + 1) & 16'hFFFF;
    end else begin
      col_pos = c + 1;
    end
    return res;
  endfunction

  task automatic reg_write(edd_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1; cfg_pwrite <= 1;
    cfg_paddr <= edd_pkg::CfgAddrW'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      edd_pkg::REG_WIDTH: fw = val[11:0];
      edd_pkg::REG_HEIGHT: fh = val[15:0];
      edd_pkg::REG_LEVELS: lvls = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_pix.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid <= 1; in_pix.blue_in <= b; in_pix.green_in <= g; in_pix.red_in <= r;
    do @(posedge clk); while (!in_pix.ready);
    dither_expect.push_back(dither_pixel(b, g, r));
  endtask

  task automatic drain;
    in_pix.valid <= 0;
    while (dither_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result side: random stalls per beat, some beats taken with no stall
  initial begin
    bit quiet;
    int n;
    n = -1;
    out_res.ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_res.valid && out_res.ready) begin
          if (dither_expect.size() == 0) begin
            $display("%0t: unexpected beat %h %h %h %b", $time, out_res.blue_out,
                     out_res.green_out, out_res.red_out, out_res.frame_done);
            fails++;
          end else begin
            pix_res_t e;
            e = dither_expect.pop_front();
            if (e !== {out_res.blue_out, out_res.green_out, out_res.red_out,
                       out_res.frame_done}) begin
              $display("%0t: expected b=%0d g=%0d r=%0d done=%b got b=%0d g=%0d r=%0d done=%b",
                       $time, e.b, e.g, e.r, e.done, out_res.blue_out, out_res.green_out,
                       out_res.red_out, out_res.frame_done);
              fails++;
            end
          end
          out_res.ready <= 0;
          n = -1;
        end
        if (!out_res.ready) begin
          if (n < 0) begin
            quiet = $urandom_range(0, 3) == 0;
            n = quiet ? 0 : $urandom_range(0, 14);
          end
          if (n == 0) out_res.ready <= 1;
          else n--;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("error_diffusion_dither_test: FAIL");
      $finish;
    end
  end

  stim_row_t dir_tab[$];

  function automatic stim_row_t row(logic [7:0] b, g, r, bit hx, logic [7:0] xb, xg, xr);
    stim_row_t s;
    s.b = b; s.g = g; s.r = r; s.has_x = hx; s.xb = xb; s.xg = xg; s.xr = xr;
    return s;
  endfunction

  initial begin
    bit gaps;
    int w;
    in_pix.valid = 0; in_pix.blue_in = 0; in_pix.green_in = 0; in_pix.red_in = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // width 4, height 2, one level: extremes, first pixel known at a glance
    reg_write(edd_pkg::REG_WIDTH, 4);
    reg_write(edd_pkg::REG_HEIGHT, 2);
    dir_tab.push_back(row(8'hFF, 8'h00, 8'h80, 1, 8'hFF, 8'h00, 8'hFF));
    dir_tab.push_back(row(8'h00, 8'hFF, 8'h7F, 0, 0, 0, 0));
    dir_tab.push_back(row(8'hAA, 8'h55, 8'h01, 0, 0, 0, 0));
    dir_tab.push_back(row(8'hFE, 8'hFF, 8'hFF, 0, 0, 0, 0));
    dir_tab.push_back(row(8'h00, 8'h00, 8'h00, 0, 0, 0, 0));
    dir_tab.push_back(row(8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0));
    dir_tab.push_back(row(8'h80, 8'h7F, 8'h80, 0, 0, 0, 0));
    dir_tab.push_back(row(8'h40, 8'hC0, 8'h20, 0, 0, 0, 0));
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_x) begin
        pix_res_t hold;
        send_pixel(dir_tab[i].b, dir_tab[i].g, dir_tab[i].r, 0);
        hold = dither_expect[$];
        if (hold.b !== dir_tab[i].xb || hold.g !== dir_tab[i].xg ||
            hold.r !== dir_tab[i].xr) begin
          $display("%0t: predictor expected %0d %0d %0d got %0d %0d %0d", $time,
                   dir_tab[i].xb, dir_tab[i].xg, dir_tab[i].xr, hold.b, hold.g, hold.r);
          fails++;
        end
      end else send_pixel(dir_tab[i].b, dir_tab[i].g, dir_tab[i].r, 0);
    end
    drain();
    // zero levels, zero width, zero height, max levels
    reg_write(edd_pkg::REG_LEVELS, 0);
    reg_write(edd_pkg::REG_WIDTH, 0);
    reg_write(edd_pkg::REG_HEIGHT, 0);
    repeat (3) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 0);
    drain();
    reg_write(edd_pkg::REG_LEVELS, 255);
    reg_write(edd_pkg::REG_WIDTH, 3);
    reg_write(edd_pkg::REG_HEIGHT, 3);
    repeat (9) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1);
    drain();
    // shrink mid-frame: after two pixels, width and height to 1
    send_pixel(8'h10, 8'h20, 8'h30, 0);
    send_pixel(8'h90, 8'hA0, 8'hB0, 0);
    drain();
    reg_write(edd_pkg::REG_WIDTH, 1);
    reg_write(edd_pkg::REG_HEIGHT, 1);
    repeat (3) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 0);
    drain();
    // width 4095 clamps to 2048: part of a wide row
    reg_write(edd_pkg::REG_WIDTH, 4095);
    reg_write(edd_pkg::REG_HEIGHT, 1);
    reg_write(edd_pkg::REG_LEVELS, 3);
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 0);
    drain();
    reg_write(edd_pkg::REG_HEIGHT, 65535);
    reg_write(edd_pkg::REG_WIDTH, 2048);
    send_pixel(8'h55, 8'hAA, 8'h11, 0);
    drain();
    // random phases: small frames, settings changed between phases
    for (int ph = 0; ph < 12; ph++) begin
      w = $urandom_range(1, 8);
      reg_write(edd_pkg::REG_WIDTH, w);
      reg_write(edd_pkg::REG_HEIGHT, $urandom_range(1, 6));
      reg_write(edd_pkg::REG_LEVELS, ph == 0 ? 1 : (ph == 1 ? 255 : $urandom_range(1, 255)));
      gaps = $urandom_range(0, 2) != 0;
      for (int i = 0; i < w * fh; i++)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gaps);
      drain();
    end
    for (int i = 0; i < 300; i++) begin
      gaps = (i / 40) % 2 == 0;
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gaps);
    end
    drain();
    if (fails == 0) $display("error_diffusion_dither_test: PASS");
    else $display("error_diffusion_dither_test: FAIL");
    $finish;
  end
endmodule
